/* rtl/sem_pkg.sv */
// Shared types and constants for the Sobel edge magnitude block.
package sem_pkg;

   localparam int PIX_W          = 8;
   localparam int CFG_W          = 9;
   localparam int CSR_IDX_W      = 1;
   localparam int POS_W          = 8;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int MIN_SIZE       = 3;
   localparam int ROOT_STEPS     = 8;
   localparam int ROOT_CNT_W     = $clog2(ROOT_STEPS);

   localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
   localparam logic [PIX_W-1:0] MAG_MAX   = 8'd255;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_SHIFT,
      S_GRAD,
      S_SQUARE,
      S_SUM,
      S_ROOT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic shift;
      logic grad;
      logic square;
      logic sum;
      logic root_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic root_last;
      logic out_free;
   } status_type;

endpackage

/* rtl/sobel_edge_magnitude.sv */
// Top level of the Sobel 3x3 gradient magnitude block.
//
//  channel | dir | handshake                | payload
//  req     | in  | req_tvalid / req_tready  | tdata: pixel[7:0]; tuser: frame_start
//  rsp     | out | rsp_tvalid / rsp_tready  | tdata: magnitude, center_row, center_col
//  csr     | in  | csr_valid / csr_ready    | csr_index, csr_data (9 bits)
//
// A border pixel passes through accept, line store read, and store write-back and shift.
// An interior pixel goes on through gradient, squaring, sum, an 8-step root unit and emit.
// One pixel is in flight at a time; the next is taken once the previous is finished.
// A stalled result sits in the output register while the next pixel is worked on.
// Reset is synchronous; line stores are not cleared, so no clearing pass is needed.
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sem_pkg::PIX_W-1:0]     req_tdata,  // [7:0] pixel
   input  logic                          req_tuser,  // [0] frame_start
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [3*sem_pkg::PIX_W-1:0]   rsp_tdata,  // [7:0] magnitude, [15:8] center_row,
                                                     // [23:16] center_col
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sem_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sem_pkg::CFG_W-1:0]     csr_data
);
   import sem_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   sem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sem_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .pixel       (req_tdata),
      .frame_start (req_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

/* rtl/sem_ctrl.sv */
// Controller state machine sequencing one pixel at a time through the datapath.
module sem_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sem_pkg::status_type status,
   output sem_pkg::cmd_type    cmd
);
   import sem_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_FETCH;
         end
         S_FETCH:  state_in = S_SHIFT;
         S_SHIFT: begin
            // border pixels end here
            state_in = status.emit ? S_GRAD : S_IDLE;
         end
         S_GRAD:   state_in = S_SQUARE;
         S_SQUARE: state_in = S_SUM;
         S_SUM:    state_in = S_ROOT;
         S_ROOT: begin
            if (status.root_last) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         S_FETCH:  cmd.fetch     = 1'b1;
         S_SHIFT:  cmd.shift     = 1'b1;
         S_GRAD:   cmd.grad      = 1'b1;
         S_SQUARE: cmd.square    = 1'b1;
         S_SUM:    cmd.sum       = 1'b1;
         S_ROOT:   cmd.root_step = 1'b1;
         S_EMIT:   cmd.load_out  = status.out_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/sem_dpath.sv */
// Datapath: size registers, position counters, line stores, window, gradient and root.
module sem_dpath #(
   parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sem_pkg::cmd_type                cmd,
   output sem_pkg::status_type             status,
   input  logic [sem_pkg::PIX_W-1:0]       pixel,
   input  logic                            frame_start,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [sem_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sem_pkg::CFG_W-1:0]       csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [3*sem_pkg::PIX_W-1:0]     rsp_tdata
);
   import sem_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int SWN = $clog2(MAX_WIDTH + 1);
   localparam int SHN = $clog2(MAX_HEIGHT + 1);
   localparam int SW  = (SWN > CFG_W) ? SWN : CFG_W;
   localparam int SH  = (SHN > CFG_W) ? SHN : CFG_W;
   localparam int PCW = (CW > POS_W) ? CW : POS_W;
   localparam int PRW = (RW > POS_W) ? RW : POS_W;

   // size registers
   logic [CFG_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET;
         height_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            REG_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [SW-1:0] size_w;
   logic [SH-1:0] size_h;

   always_comb begin
      if (SW'(width_ff) < SW'(MIN_SIZE))       size_w = SW'(MIN_SIZE);
      else if (SW'(width_ff) > SW'(MAX_WIDTH)) size_w = SW'(MAX_WIDTH);
      else                                     size_w = SW'(width_ff);
      if (SH'(height_ff) < SH'(MIN_SIZE))        size_h = SH'(MIN_SIZE);
      else if (SH'(height_ff) > SH'(MAX_HEIGHT)) size_h = SH'(MAX_HEIGHT);
      else                                       size_h = SH'(height_ff);
   end

   // position counters
   logic [CW-1:0] col_ff, col_in, c_cur, idx_ff, pos_c_ff;
   logic [RW-1:0] row_ff, row_in, r_cur, pos_r_ff;
   logic          emit_ff, emit_in;
   logic [PIX_W-1:0] px_ff;
   logic          last_col;

   always_comb begin
      c_cur    = frame_start ? '0 : col_ff;
      r_cur    = frame_start ? '0 : row_ff;
      last_col = (SW'(c_cur) + SW'(1)) >= size_w;
      col_in   = last_col ? '0 : CW'(SW'(c_cur) + SW'(1));
      if (!last_col)                              row_in = r_cur;
      else if ((SH'(r_cur) + SH'(1)) >= size_h)   row_in = '0;
      else                                        row_in = RW'(SH'(r_cur) + SH'(1));
      emit_in  = (SH'(r_cur) >= SH'(2)) && (SW'(c_cur) >= SW'(2)) &&
                 (SH'(r_cur) < size_h) && (SW'(c_cur) < size_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         emit_ff <= 1'b0;
      end else if (cmd.accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         emit_ff <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         idx_ff   <= c_cur;
         pos_c_ff <= c_cur;
         pos_r_ff <= r_cur;
         px_ff    <= pixel;
      end
   end

   // line stores: read in fetch, write back in shift
   logic [PIX_W-1:0] line_store_a [MAX_WIDTH];
   logic [PIX_W-1:0] line_store_b [MAX_WIDTH];
   logic [PIX_W-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_a_ff <= line_store_a[idx_ff];
         rd_b_ff <= line_store_b[idx_ff];
      end
      if (cmd.shift) begin
         line_store_b[idx_ff] <= rd_a_ff;
         line_store_a[idx_ff] <= px_ff;
      end
   end

   // 3x3 window, newest column on the right
   logic [PIX_W-1:0] win_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (cmd.shift) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= rd_b_ff;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= rd_a_ff;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= px_ff;
      end
   end

   // gradients as positive and negative kernel sums, kept as magnitudes
   logic [9:0] gx_pos, gx_neg, gy_pos, gy_neg;
   logic [9:0] ax_ff, ay_ff;

   always_comb begin
      gx_pos = 10'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + 10'(win_ff[8]);
      gx_neg = 10'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + 10'(win_ff[6]);
      gy_pos = 10'(win_ff[6]) + {1'b0, win_ff[7], 1'b0} + 10'(win_ff[8]);
      gy_neg = 10'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + 10'(win_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         ax_ff <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
         ay_ff <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
      end
   end

   logic [19:0] sqx_ff, sqy_ff;
   logic [20:0] sum;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sqx_ff <= {10'b0, ax_ff} * {10'b0, ax_ff};
         sqy_ff <= {10'b0, ay_ff} * {10'b0, ay_ff};
      end
   end

   assign sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // digit-by-digit root over the low 16 bits, one result bit a step
   logic [15:0]           val_ff;
   logic [8:0]            rem_ff;
   logic [7:0]            root_ff;
   logic                  sat_ff;
   logic [ROOT_CNT_W-1:0] cnt_ff;
   logic [10:0]           rem2, trial, diff;
   logic                  ge;

   always_comb begin
      rem2  = {rem_ff, val_ff[15:14]};
      trial = {1'b0, root_ff, 2'b01};
      ge    = rem2 >= trial;
      diff  = rem2 - trial;
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         val_ff  <= sum[15:0];
         sat_ff  <= |sum[20:16];
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.root_step) begin
         val_ff  <= {val_ff[13:0], 2'b00};
         rem_ff  <= ge ? diff[8:0] : rem2[8:0];
         root_ff <= {root_ff[6:0], ge};
         cnt_ff  <= cnt_ff + ROOT_CNT_W'(1);
      end
   end

   // result register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] mag_ff, out_row_ff, out_col_ff;
   logic [PRW-1:0]   row_m1;
   logic [PCW-1:0]   col_m1;

   assign row_m1 = PRW'(pos_r_ff) - PRW'(1);
   assign col_m1 = PCW'(pos_c_ff) - PCW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         mag_ff     <= sat_ff ? MAG_MAX : root_ff;
         out_row_ff <= row_m1[POS_W-1:0];
         out_col_ff <= col_m1[POS_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_col_ff, out_row_ff, mag_ff};

   assign status.emit      = emit_ff;
   assign status.root_last = (cnt_ff == ROOT_CNT_W'(ROOT_STEPS - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

`ifndef SYNTHESIS
   a_frame_start_origin: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && frame_start |=> pos_c_ff == '0 && pos_r_ff == '0)
      else $error("frame start did not force origin");

   a_load_only_interior: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> emit_ff)
      else $error("result loaded for a border pixel");

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   a_root_done_once: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !$past(cmd.sum))
      else $error("result loaded before root finished");
`endif

endmodule

/* dv/tb_sobel_edge_magnitude.sv */
// Self-checking testbench for the Sobel edge magnitude block.
module tb_sobel_edge_magnitude;
   import sem_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_WAIT  = 40;

   typedef struct packed {
      logic [7:0] center_col;
      logic [7:0] center_row;
      logic [7:0] magnitude;
   } sobel_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata;   // [7:0] pixel
   logic                 req_tuser;   // [0] frame_start
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [3*PIX_W-1:0]   rsp_tdata;   // [7:0] magnitude, [15:8] center_row, [23:16] center_col
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   // Predictor state
   logic [7:0]           line_prev [DEF_MAX_WIDTH] = '{default: '0};
   logic [7:0]           line_prev2 [DEF_MAX_WIDTH] = '{default: '0};
   bit                   prev_written [DEF_MAX_WIDTH];
   bit                   prev2_written [DEF_MAX_WIDTH];
   logic [7:0]           win [9] = '{default: '0};
   int                   col_pos = 0;
   int                   row_pos = 0;
   logic [CFG_W-1:0]     cfg_width = CFG_RESET;
   logic [CFG_W-1:0]     cfg_height = CFG_RESET;

   sobel_result_type     expected_edges [$];
   int                   mismatches = 0;
   int                   send_idle_pct = 7;
   int                   recv_idle_pct = 66;
   int                   stall_cycles = 0;
   int                   cycle_count = 0;
   logic [7:0]           smooth_base = 8'd128;

   sobel_edge_magnitude i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   function automatic int clamp_size(int value, int hi);
      if (value < MIN_SIZE) return MIN_SIZE;
      if (value > hi) return hi;
      return value;
   endfunction

   // Advance the predictor by one accepted pixel and queue the edge result it yields.
   function automatic void predict_sobel_pixel(logic [7:0] px, logic marker);
      int               w, h, c, r, gx, gy, mag2, root;
      logic [7:0]       top, mid;
      sobel_result_type res;
      w = clamp_size(int'(cfg_width), DEF_MAX_WIDTH);
      h = clamp_size(int'(cfg_height), DEF_MAX_HEIGHT);
      if (marker) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      top = line_prev2[c];
      mid = line_prev[c];
      line_prev2[c] = mid;
      line_prev[c] = px;
      prev2_written[c] = prev_written[c];
      prev_written[c] = 1'b1;
      win[0] = win[1]; win[1] = win[2]; win[2] = top;
      win[3] = win[4]; win[4] = win[5]; win[5] = mid;
      win[6] = win[7]; win[7] = win[8]; win[8] = px;
      if (r >= 2 && c >= 2 && r < h && c < w) begin
         gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
            - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
         gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
            - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
         mag2 = gx * gx + gy * gy;
         root = 0;
         // floor root, saturated at the top code
         while (root < int'(MAG_MAX) && (root + 1) * (root + 1) <= mag2) root++;
         res.magnitude  = 8'(root);
         res.center_row = 8'(r - 1);
         res.center_col = 8'(c - 1);
         expected_edges.push_back(res);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(3))
         0: return 8'($urandom);
         1: return $urandom_range(1) ? 8'hFF : 8'h00;
         default: begin
            // drift slowly so that magnitudes below saturation turn up
            smooth_base = smooth_base + 8'($urandom_range(2)) - 8'd1;
            return smooth_base + 8'($urandom_range(3));
         end
      endcase
   endfunction

   task automatic send_pixel(input logic [7:0] px, input logic marker);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = px;
      req_tuser  = marker;
      do @(posedge clock); while (!req_tready);
      predict_sobel_pixel(px, marker);
   endtask

   task automatic send_run(input int count, input int marker_pct, input bit open_marker);
      for (int i = 0; i < count; i++) begin
         send_pixel(rand_pixel(), (i == 0 && open_marker) || ($urandom_range(99) < marker_pct));
      end
   endtask

   // Hold the input and wait until the block has nothing left in flight.
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_size_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_IMAGE_WIDTH) cfg_width = value;
      else cfg_height = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      sobel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_edges.size() == 0) begin
            $error("unexpected result beat: tdata=%h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_edges.pop_front();
            if (rsp_tdata[7:0] !== want.magnitude) begin
               $error("magnitude: expected %0d, got %0d", want.magnitude, rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tdata[15:8] !== want.center_row) begin
               $error("center_row: expected %0d, got %0d", want.center_row, rsp_tdata[15:8]);
               mismatches++;
            end
            if (rsp_tdata[23:16] !== want.center_col) begin
               $error("center_col: expected %0d, got %0d", want.center_col, rsp_tdata[23:16]);
               mismatches++;
            end
         end
      end
   end

   initial begin : receiver
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_cycles > 0) begin
            rsp_tready = 1'b0;
            stall_cycles--;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Saturated vertical and horizontal steps, a wrap without marker, a restart, a mild slope.
   task automatic test_directed_frames();
      logic [7:0] step_v [9] = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
      logic [7:0] step_h [9] = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      logic [7:0] slope [9] = '{8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd13};
      // sizes below the minimum clamp to a 3x3 frame
      write_size_reg(REG_IMAGE_WIDTH, 9'd0);
      write_size_reg(REG_IMAGE_HEIGHT, 9'd2);
      for (int i = 0; i < 9; i++) send_pixel(step_v[i], i == 0);
      for (int i = 0; i < 9; i++) send_pixel(step_h[i], 1'b0);
      send_pixel(8'd77, 1'b0);
      for (int i = 0; i < 9; i++) send_pixel(slope[i], i == 0);
   endtask

   task automatic test_small_frames();
      int wc, hc;
      for (int k = 0; k < 10; k++) begin
         settle();
         if (k == 0) begin
            write_size_reg(REG_IMAGE_WIDTH, 9'd2);
            write_size_reg(REG_IMAGE_HEIGHT, 9'd511);
         end else begin
            write_size_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, 8)));
            write_size_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 6)));
         end
         wc = clamp_size(int'(cfg_width), DEF_MAX_WIDTH);
         hc = clamp_size(int'(cfg_height), DEF_MAX_HEIGHT);
         send_run(wc * (k == 0 ? 8 : hc) + $urandom_range(0, 2 * wc), 2, 1'b1);
      end
   endtask

   task automatic test_size_extremes();
      settle();
      write_size_reg(REG_IMAGE_WIDTH, 9'd511);
      write_size_reg(REG_IMAGE_HEIGHT, 9'd0);
      send_run(540, 0, 1'b1);
      // shrink the row while the column count lies past the new width
      settle();
      write_size_reg(REG_IMAGE_WIDTH, 9'd5);
      send_run(40, 0, 1'b0);
      settle();
      write_size_reg(REG_IMAGE_WIDTH, 9'd3);
      write_size_reg(REG_IMAGE_HEIGHT, 9'd256);
      send_run(120, 0, 1'b1);
      // cut the frame short below the current row
      settle();
      write_size_reg(REG_IMAGE_HEIGHT, 9'd4);
      send_run(30, 0, 1'b0);
   endtask

   task automatic test_output_stall();
      settle();
      write_size_reg(REG_IMAGE_WIDTH, 9'd5);
      write_size_reg(REG_IMAGE_HEIGHT, 9'd5);
      @(posedge clock);
      stall_cycles = 400;
      send_run(60, 0, 1'b1);
   endtask

   task automatic test_random_mix();
      int  new_w, wc;
      bit  primed;
      repeat (8) begin
         settle();
         new_w = $urandom_range(0, 14);
         wc = clamp_size(new_w, DEF_MAX_WIDTH);
         primed = 1'b1;
         for (int c = 0; c < wc; c++) if (!prev2_written[c]) primed = 1'b0;
         write_size_reg(REG_IMAGE_WIDTH, CFG_W'(new_w));
         write_size_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 9)));
         // restart the frame if any column now in use has not been stored twice, else at random
         send_run(wc * 3 + $urandom_range(0, 20), 3, !primed || $urandom_range(1));
      end
   endtask

   initial begin : stimulus
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = REG_IMAGE_WIDTH;
      csr_data   = '0;
      reset      = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 7;
      recv_idle_pct = 66;
      test_directed_frames();
      test_small_frames();

      send_idle_pct = 66;
      recv_idle_pct = 7;
      test_size_extremes();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_output_stall();
      test_random_mix();

      settle();
      if (expected_edges.size() != 0) begin
         $error("%0d expected results never arrived", expected_edges.size());
         mismatches++;
      end
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
